>>> sv/nfba_pkg.sv
// Shared types and codes for the next-fit block allocator.
`default_nettype none
package nfba_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_NOTBLOCK = 3'd3,
        ST_FREE     = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [14:0] {
        S_CLR   = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_ACURD = 15'b000000000000100,
        S_CHK   = 15'b000000000001000,
        S_PD    = 15'b000000000010000,
        S_MRG   = 15'b000000000100000,
        S_ND    = 15'b000000001000000,
        S_WP    = 15'b000000010000000,
        S_TAKE  = 15'b000000100000000,
        S_TAKE2 = 15'b000001000000000,
        S_RD    = 15'b000010000000000,
        S_DONE  = 15'b000100000000000,
        S_PEND  = 15'b001000000000000,
        S_ACUR  = 15'b010000000000000,
        S_REL   = 15'b100000000000000
    } state_t;

endpackage
`default_nettype wire

>>> sv/nfba_heap_mem.sv
// Block header memory: header mark, use mark and length per heap unit.
`default_nettype none
module nfba_heap_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/next_fit_block_allocator.sv
// Next-fit heap allocator with merging of free neighbors, top level.
//
// channel  dir  tdata                                   tuser
// s_*      in   [9:0] request_size, [19:10] data_offset  [0] opcode
// m_*      out  [2:0] status, [12:3] granted_offset       -
//
// Release checks the header and clears its use mark; allocate first tries the block at
// the cursor, else visits block headers from the cursor to the heap end, then from the
// start up to the cursor, merging free neighbors, and takes the first block that fits.
// After reset a clearing pass writes every header memory unit with s_tready low.
// One item is in work at a time; a finished result waits in the output register.
`default_nettype none
module next_fit_block_allocator #(
    parameter int HEAP_UNITS   = 1024,
    parameter int HEADER_UNITS = 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // request_size, data_offset, zero pad
    input  wire logic [0:0]  s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // status, granted_offset, zero pad
);

    localparam int AW = $clog2(HEAP_UNITS);
    localparam int W  = ((AW > 10) ? AW : 10) + 2;
    localparam int DW = AW + 2;
    localparam logic [W-1:0] HDR  = W'(HEADER_UNITS);
    localparam logic [W-1:0] HEAP = W'(HEAP_UNITS);
    localparam logic [AW-1:0] LEN0 = AW'(HEAP_UNITS - HEADER_UNITS);

    nfba_pkg::state_t state_reg, state_next;
    logic [AW:0]   clr_reg, clr_next;
    logic [W-1:0]  p_reg, p_next, end_reg, end_next, nx_reg, nx_next;
    logic          pass_reg, pass_next;
    logic [9:0]    size_reg, size_next, off_reg, off_next;
    logic          use_reg, use_next, dirty_reg, dirty_next;
    logic [AW-1:0] len_reg, len_next, rest_reg, rest_next;
    logic          cv_reg, cv_next;
    logic [AW-1:0] cp_reg, cp_next;
    nfba_pkg::status_t stat_reg, stat_next;
    logic [9:0]    grant_reg, grant_next;
    logic          ov_reg, ov_next;
    logic [15:0]   od_reg, od_next;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    logic          r_hdr, r_use;
    logic [AW-1:0] r_len;
    logic [W-1:0]  cur_w, end2, nx_calc, take_nx;
    logic          cur_in;

    nfba_heap_mem #(.DEPTH(HEAP_UNITS), .AW(AW), .DW(DW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr), .rdata(rdata)
    );

    assign r_hdr   = rdata[DW-1];
    assign r_use   = rdata[DW-2];
    assign r_len   = rdata[AW-1:0];
    assign cur_w   = W'(cp_reg);
    assign cur_in  = cur_w < HEAP;
    assign end2    = (cv_reg && cur_in) ? cur_w : HEAP;
    assign nx_calc = p_reg + HDR + W'(len_reg);
    assign take_nx = p_reg + HDR + W'(size_reg);

    assign s_tready = (state_reg == nfba_pkg::S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        p_next     = p_reg;
        end_next   = end_reg;
        nx_next    = nx_reg;
        pass_next  = pass_reg;
        size_next  = size_reg;
        off_next   = off_reg;
        use_next   = use_reg;
        dirty_next = dirty_reg;
        len_next   = len_reg;
        rest_next  = rest_reg;
        cv_next    = cv_reg;
        cp_next    = cp_reg;
        stat_next  = stat_reg;
        grant_next = grant_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        we         = 1'b0;
        waddr      = p_reg[AW-1:0];
        wdata      = '0;
        re         = 1'b0;
        raddr      = p_reg[AW-1:0];

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            nfba_pkg::S_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = (clr_reg == '0) ? {1'b1, 1'b0, LEN0} : '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(HEAP_UNITS - 1))
                begin
                    state_next = nfba_pkg::S_IDLE;
                end
            end
            nfba_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    size_next  = s_tdata[9:0];
                    off_next   = s_tdata[19:10];
                    grant_next = '0;
                    stat_next  = nfba_pkg::ST_OK;
                    dirty_next = 1'b0;
                    if (s_tuser[0] == nfba_pkg::OP_RELEASE)
                    begin
                        state_next = nfba_pkg::S_REL;
                    end
                    else if (s_tdata[9:0] == '0)
                    begin
                        stat_next  = nfba_pkg::ST_ZERO;
                        state_next = nfba_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = nfba_pkg::S_ACUR;
                    end
                end
            end
            nfba_pkg::S_ACUR:
            begin
                re    = 1'b1;
                raddr = cp_reg;
                state_next = nfba_pkg::S_ACURD;
            end
            nfba_pkg::S_ACURD:
            begin
                if (cv_reg && cur_in && r_hdr && !r_use &&
                    W'(r_len) >= W'(size_reg) + HDR)
                begin
                    p_next     = cur_w;
                    len_next   = r_len;
                    state_next = nfba_pkg::S_TAKE;
                end
                else if (cv_reg && cur_in && r_hdr)
                begin
                    p_next     = cur_w;
                    end_next   = HEAP;
                    pass_next  = 1'b0;
                    state_next = nfba_pkg::S_CHK;
                end
                else
                begin
                    p_next     = '0;
                    end_next   = end2;
                    pass_next  = 1'b1;
                    state_next = nfba_pkg::S_CHK;
                end
            end
            nfba_pkg::S_CHK:
            begin
                dirty_next = 1'b0;
                if ((take_nx <= end_reg) && (p_reg < HEAP))
                begin
                    re         = 1'b1;
                    state_next = nfba_pkg::S_PD;
                end
                else
                begin
                    state_next = nfba_pkg::S_PEND;
                end
            end
            nfba_pkg::S_PD:
            begin
                use_next = r_use;
                len_next = r_len;
                state_next = r_hdr ? nfba_pkg::S_MRG : nfba_pkg::S_PEND;
            end
            nfba_pkg::S_MRG:
            begin
                nx_next = nx_calc;
                if (!use_reg && nx_calc < end_reg && nx_calc < HEAP)
                begin
                    re         = 1'b1;
                    raddr      = nx_calc[AW-1:0];
                    state_next = nfba_pkg::S_ND;
                end
                else
                begin
                    state_next = nfba_pkg::S_WP;
                end
            end
            nfba_pkg::S_ND:
            begin
                if (r_hdr && !r_use)
                begin
                    we         = 1'b1;
                    waddr      = nx_reg[AW-1:0];
                    wdata      = '0;
                    len_next   = len_reg + HDR[AW-1:0] + r_len;
                    dirty_next = 1'b1;
                    state_next = nfba_pkg::S_MRG;
                end
                else
                begin
                    state_next = nfba_pkg::S_WP;
                end
            end
            nfba_pkg::S_WP:
            begin
                if (dirty_reg)
                begin
                    we    = 1'b1;
                    wdata = {1'b1, 1'b0, len_reg};
                end
                if (!use_reg && W'(len_reg) >= W'(size_reg))
                begin
                    state_next = nfba_pkg::S_TAKE;
                end
                else
                begin
                    p_next     = nx_calc;
                    state_next = nfba_pkg::S_CHK;
                end
            end
            nfba_pkg::S_PEND:
            begin
                if (!pass_reg)
                begin
                    p_next     = '0;
                    end_next   = end2;
                    pass_next  = 1'b1;
                    state_next = nfba_pkg::S_CHK;
                end
                else
                begin
                    stat_next  = nfba_pkg::ST_NOSPACE;
                    state_next = nfba_pkg::S_DONE;
                end
            end
            nfba_pkg::S_TAKE:
            begin
                we         = 1'b1;
                wdata      = {1'b1, 1'b1, len_reg};
                grant_next = 10'(p_reg + HDR);
                state_next = nfba_pkg::S_DONE;
                if (W'(len_reg) > W'(size_reg))
                begin
                    if ((W'(len_reg) - W'(size_reg) > HDR) && (take_nx < HEAP))
                    begin
                        wdata      = {1'b1, 1'b1, AW'(size_reg)};
                        nx_next    = take_nx;
                        rest_next  = AW'(W'(len_reg) - W'(size_reg) - HDR);
                        state_next = nfba_pkg::S_TAKE2;
                    end
                    else
                    begin
                        cv_next = 1'b0;
                        cp_next = '0;
                    end
                end
            end
            nfba_pkg::S_TAKE2:
            begin
                we         = 1'b1;
                waddr      = nx_reg[AW-1:0];
                wdata      = {1'b1, 1'b0, rest_reg};
                cv_next    = 1'b1;
                cp_next    = nx_reg[AW-1:0];
                state_next = nfba_pkg::S_DONE;
            end
            nfba_pkg::S_REL:
            begin
                p_next = W'(off_reg) - HDR;
                if (W'(off_reg) < HDR || W'(off_reg) - HDR >= HEAP)
                begin
                    stat_next  = nfba_pkg::ST_NOTBLOCK;
                    state_next = nfba_pkg::S_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = AW'(W'(off_reg) - HDR);
                    state_next = nfba_pkg::S_RD;
                end
            end
            nfba_pkg::S_RD:
            begin
                state_next = nfba_pkg::S_DONE;
                if (!r_hdr)
                begin
                    stat_next = nfba_pkg::ST_NOTBLOCK;
                end
                else if (!r_use)
                begin
                    stat_next = nfba_pkg::ST_FREE;
                end
                else
                begin
                    we    = 1'b1;
                    wdata = {1'b1, 1'b0, r_len};
                end
            end
            nfba_pkg::S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = {3'b000, grant_reg, stat_reg};
                    state_next = nfba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nfba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfba_pkg::S_CLR;
            clr_reg   <= '0;
            cv_reg    <= 1'b1;
            cp_reg    <= '0;
            ov_reg    <= 1'b0;
            pass_reg  <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cv_reg    <= cv_next;
            cp_reg    <= cp_next;
            ov_reg    <= ov_next;
            pass_reg  <= pass_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        end_reg   <= end_next;
        nx_reg    <= nx_next;
        size_reg  <= size_next;
        off_reg   <= off_next;
        use_reg   <= use_next;
        len_reg   <= len_next;
        rest_reg  <= rest_next;
        stat_reg  <= stat_next;
        grant_reg <= grant_next;
        od_reg    <= od_next;
    end

endmodule
`default_nettype wire
